@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold whenever the antecedent is true, outside reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// condition that must never be true, outside reset
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition");

`endif

@@ hdl/efi_pkg.sv @@
package efi_pkg;

    localparam int COORD_MAX   = 1024;
    localparam int COORD_W     = $clog2(COORD_MAX);
    localparam int FRAC_BITS   = 28;
    localparam int VAL_W       = 32;
    localparam int SCALE_W     = 31;
    localparam int LIMIT_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int HUE_W       = 4;
    localparam int PIXEL_W     = COLOR_W + HUE_W;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int MAP_W       = COORD_W + SCALE_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [VAL_W-1:0] val_t;

    // mode register codes, the remaining code runs as mandelbrot
    localparam logic [MODE_W-1:0] MODE_MANDEL    = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_JULIA     = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_JULIA_FIX = MODE_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_IM  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR = CFG_IDX_W'(7);

    // fixed julia constant 0.1 + 0.65i, rounded to nearest
    localparam val_t FIX_C_RE = VAL_W'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam val_t FIX_C_IM = VAL_W'(((64'sd13 <<< FRAC_BITS) + 64'sd10) / 64'sd20);

    // |z|^2 bound of 4.0
    localparam logic [VAL_W:0] ESCAPE_BOUND = (VAL_W + 1)'(4) << FRAC_BITS;

    typedef enum logic {
        F_IDLE,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_CHK,
        C_DONE
    } core_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SCALE_W-1:0] scale;
        val_t               offset_re;
        val_t               offset_im;
        val_t               julia_re;
        val_t               julia_im;
        logic [LIMIT_W-1:0] iter_limit;
        logic [COLOR_W-1:0] base_color;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:       MODE_MANDEL,
        scale:      SCALE_W'(1048576),
        offset_re:  VAL_W'(-64'sd536870912),
        offset_im:  VAL_W'(-64'sd536870912),
        julia_re:   VAL_W'(0),
        julia_im:   VAL_W'(0),
        iter_limit: LIMIT_W'(50),
        base_color: COLOR_W'(24'hFFFFFF)
    };

    // one queued point: pixel echo plus start value and constant
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        val_t               zr;
        val_t               zi;
        val_t               cr;
        val_t               ci;
    } item_t;

    // clamp a wide signed value to the plane value range
    function automatic val_t sat_val(input logic signed [PROD_W-1:0] v);
        logic fits;
        val_t res;
        fits = (&v[PROD_W-1:VAL_W-1]) || !(|v[PROD_W-1:VAL_W-1]);
        if (fits)
        begin
            res = v[VAL_W-1:0];
        end
        else if (v[PROD_W-1])
        begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ hdl/efi_fifo.sv @@
module efi_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  efi_pkg::item_t  push_item,
    input  logic            pop,
    output efi_pkg::item_t  pop_item,
    output logic            full,
    output logic            empty
);

    efi_pkg::item_t                   mem_reg [efi_pkg::QUEUE_DEPTH];
    logic [efi_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [efi_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [efi_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [efi_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [efi_pkg::QCNT_W-1:0]       count_reg;
    logic [efi_pkg::QCNT_W-1:0]       count_next;

    function automatic logic [efi_pkg::QPTR_W-1:0] ptr_inc(
        input logic [efi_pkg::QPTR_W-1:0] p
    );
        logic [efi_pkg::QPTR_W-1:0] r;
        if (p == efi_pkg::QPTR_W'(efi_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + efi_pkg::QPTR_W'(1);
        end
        return r;
    endfunction

    assign full     = (count_reg == efi_pkg::QCNT_W'(efi_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + efi_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - efi_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/efi_front.sv @@
module efi_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [efi_pkg::COORD_W-1:0]  px,
    input  logic [efi_pkg::COORD_W-1:0]  py,
    input  efi_pkg::cfg_t                cfg,
    input  logic                         full,
    output logic                         push,
    output efi_pkg::item_t               push_item
);

    efi_pkg::front_state_t             state_reg;
    efi_pkg::front_state_t             state_next;
    logic [efi_pkg::COORD_W-1:0]       px_reg;
    logic [efi_pkg::COORD_W-1:0]       py_reg;
    logic [efi_pkg::MAP_W-1:0]         map_re_reg;
    logic [efi_pkg::MAP_W-1:0]         map_im_reg;
    efi_pkg::val_t                     p_re;
    efi_pkg::val_t                     p_im;

    // plane point: coord * scale + offset, saturated
    always_comb
    begin
        p_re = efi_pkg::sat_val(
            $signed({{(efi_pkg::PROD_W - efi_pkg::MAP_W){1'b0}}, map_re_reg})
            + efi_pkg::PROD_W'(cfg.offset_re));
        p_im = efi_pkg::sat_val(
            $signed({{(efi_pkg::PROD_W - efi_pkg::MAP_W){1'b0}}, map_im_reg})
            + efi_pkg::PROD_W'(cfg.offset_im));
    end

    // sort the point into start value and constant by mode
    always_comb
    begin
        push_item.px = px_reg;
        push_item.py = py_reg;
        case (cfg.mode)
            efi_pkg::MODE_JULIA:
            begin
                push_item.zr = p_re;
                push_item.zi = p_im;
                push_item.cr = cfg.julia_re;
                push_item.ci = cfg.julia_im;
            end
            efi_pkg::MODE_JULIA_FIX:
            begin
                push_item.zr = p_re;
                push_item.zi = p_im;
                push_item.cr = efi_pkg::FIX_C_RE;
                push_item.ci = efi_pkg::FIX_C_IM;
            end
            default:
            begin
                push_item.zr = '0;
                push_item.zi = '0;
                push_item.cr = p_re;
                push_item.ci = p_im;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            efi_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = efi_pkg::F_PUSH;
                end
            end
            efi_pkg::F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = efi_pkg::F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= efi_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            px_reg     <= px;
            py_reg     <= py;
            map_re_reg <= efi_pkg::MAP_W'(px) * efi_pkg::MAP_W'(cfg.scale);
            map_im_reg <= efi_pkg::MAP_W'(py) * efi_pkg::MAP_W'(cfg.scale);
        end
    end

endmodule

@@ hdl/efi_core.sv @@
module efi_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    output logic                         pop,
    input  efi_pkg::item_t               pop_item,
    input  efi_pkg::cfg_t                cfg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [efi_pkg::COORD_W-1:0]  out_px,
    output logic [efi_pkg::COORD_W-1:0]  out_py,
    output logic [efi_pkg::LIMIT_W-1:0]  iter_count,
    output logic [efi_pkg::PIXEL_W-1:0]  pixel_color
);

    efi_pkg::core_state_t                state_reg;
    efi_pkg::core_state_t                state_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [efi_pkg::COORD_W-1:0]         px_reg;
    logic [efi_pkg::COORD_W-1:0]         py_reg;
    efi_pkg::val_t                       zr_reg;
    efi_pkg::val_t                       zi_reg;
    efi_pkg::val_t                       cr_reg;
    efi_pkg::val_t                       ci_reg;
    logic [efi_pkg::LIMIT_W-1:0]         iter_reg;
    logic signed [efi_pkg::PROD_W-1:0]   p_rr_reg;
    logic signed [efi_pkg::PROD_W-1:0]   p_ii_reg;
    logic signed [efi_pkg::PROD_W-1:0]   p_ri_reg;
    logic [efi_pkg::COORD_W-1:0]         out_px_reg;
    logic [efi_pkg::COORD_W-1:0]         out_py_reg;
    logic [efi_pkg::LIMIT_W-1:0]         out_iter_reg;
    logic [efi_pkg::PIXEL_W-1:0]         out_color_reg;

    efi_pkg::val_t                       zr2;
    efi_pkg::val_t                       zi2;
    efi_pkg::val_t                       zri2;
    efi_pkg::val_t                       zr_new;
    efi_pkg::val_t                       zi_new;
    logic [efi_pkg::VAL_W:0]             mag;
    logic                                go_on;
    logic                                step;
    logic                                emit;
    logic [efi_pkg::PIXEL_W-1:0]         color;

    // squares floor-shifted by the fraction width, cross term one less (times two)
    always_comb
    begin
        zr2    = efi_pkg::sat_val(p_rr_reg >>> efi_pkg::FRAC_BITS);
        zi2    = efi_pkg::sat_val(p_ii_reg >>> efi_pkg::FRAC_BITS);
        zri2   = efi_pkg::sat_val(p_ri_reg >>> (efi_pkg::FRAC_BITS - 1));
        mag    = {1'b0, zr2} + {1'b0, zi2};
        go_on  = (iter_reg < cfg.iter_limit) && (mag < efi_pkg::ESCAPE_BOUND);
        zr_new = efi_pkg::sat_val(
            efi_pkg::PROD_W'(efi_pkg::sat_val(efi_pkg::PROD_W'(zr2) - efi_pkg::PROD_W'(zi2)))
            + efi_pkg::PROD_W'(cr_reg));
        zi_new = efi_pkg::sat_val(efi_pkg::PROD_W'(zri2) + efi_pkg::PROD_W'(ci_reg));
        if (iter_reg == cfg.iter_limit)
        begin
            color = '0;
        end
        else
        begin
            color = efi_pkg::PIXEL_W'(cfg.base_color)
                  * efi_pkg::PIXEL_W'(iter_reg[efi_pkg::HUE_W-1:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        step       = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            efi_pkg::C_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = efi_pkg::C_MUL;
                end
            end
            efi_pkg::C_MUL:
            begin
                state_next = efi_pkg::C_CHK;
            end
            efi_pkg::C_CHK:
            begin
                if (go_on)
                begin
                    step       = 1'b1;
                    state_next = efi_pkg::C_MUL;
                end
                else
                begin
                    state_next = efi_pkg::C_DONE;
                end
            end
            efi_pkg::C_DONE:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    emit       = 1'b1;
                    state_next = efi_pkg::C_IDLE;
                end
            end
        endcase
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efi_pkg::C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            px_reg   <= pop_item.px;
            py_reg   <= pop_item.py;
            zr_reg   <= pop_item.zr;
            zi_reg   <= pop_item.zi;
            cr_reg   <= pop_item.cr;
            ci_reg   <= pop_item.ci;
            iter_reg <= '0;
        end
        else if (step)
        begin
            zr_reg   <= zr_new;
            zi_reg   <= zi_new;
            iter_reg <= iter_reg + efi_pkg::LIMIT_W'(1);
        end
        if (state_reg == efi_pkg::C_MUL)
        begin
            p_rr_reg <= zr_reg * zr_reg;
            p_ii_reg <= zi_reg * zi_reg;
            p_ri_reg <= zr_reg * zi_reg;
        end
        if (emit)
        begin
            out_px_reg    <= px_reg;
            out_py_reg    <= py_reg;
            out_iter_reg  <= iter_reg;
            out_color_reg <= color;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_px      = out_px_reg;
    assign out_py      = out_py_reg;
    assign iter_count  = out_iter_reg;
    assign pixel_color = out_color_reg;

endmodule

@@ hdl/escape_time_fractal_iterator.sv @@
// Escape-time Mandelbrot/Julia pixel engine in signed Q3.28. Each accepted pixel is mapped
// to the plane by a front stage and queued; the iteration engine takes it from the queue and
// runs each iteration as a pass through its shared multiplier set (three 32x32 products,
// registered) followed by an update and escape-check state. A pixel occupies the engine
// longer the more iterations it runs, so the throughput is set by the iteration limit and
// by how fast points escape; the front maps the next pixel and the output register holds
// a finished result while the engine works. Configuration registers are written through
// the cfg channel, which is always ready.
`include "assert_macros.svh"

module escape_time_fractal_iterator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [efi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [efi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [efi_pkg::COORD_W-1:0]     px,
    input  logic [efi_pkg::COORD_W-1:0]     py,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [efi_pkg::COORD_W-1:0]     out_px,
    output logic [efi_pkg::COORD_W-1:0]     out_py,
    output logic [efi_pkg::LIMIT_W-1:0]     iter_count,
    output logic [efi_pkg::PIXEL_W-1:0]     pixel_color
);

    efi_pkg::cfg_t   cfg_reg;
    efi_pkg::cfg_t   cfg_next;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    efi_pkg::item_t  q_in_item;
    efi_pkg::item_t  q_out_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                efi_pkg::REG_MODE:       cfg_next.mode       = cfg_data[efi_pkg::MODE_W-1:0];
                efi_pkg::REG_SCALE:      cfg_next.scale      = cfg_data[efi_pkg::SCALE_W-1:0];
                efi_pkg::REG_OFFSET_RE:  cfg_next.offset_re  = cfg_data[efi_pkg::VAL_W-1:0];
                efi_pkg::REG_OFFSET_IM:  cfg_next.offset_im  = cfg_data[efi_pkg::VAL_W-1:0];
                efi_pkg::REG_JULIA_RE:   cfg_next.julia_re   = cfg_data[efi_pkg::VAL_W-1:0];
                efi_pkg::REG_JULIA_IM:   cfg_next.julia_im   = cfg_data[efi_pkg::VAL_W-1:0];
                efi_pkg::REG_ITER_LIMIT: cfg_next.iter_limit = cfg_data[efi_pkg::LIMIT_W-1:0];
                efi_pkg::REG_BASE_COLOR: cfg_next.base_color = cfg_data[efi_pkg::COLOR_W-1:0];
                default:                 cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= efi_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    efi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .px        (px),
        .py        (py),
        .cfg       (cfg_reg),
        .full      (q_full),
        .push      (q_push),
        .push_item (q_in_item)
    );

    efi_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    efi_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .pop         (q_pop),
        .pop_item    (q_out_item),
        .cfg         (cfg_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_px      (out_px),
        .out_py      (out_py),
        .iter_count  (iter_count),
        .pixel_color (pixel_color)
    );

    // queue never written when full nor read when empty
    `ASSERT_IMPLIES(a_push_has_room, q_push, !q_full)
    `ASSERT_IMPLIES(a_pop_has_data, q_pop, !q_empty)
    `ASSERT_NEVER(a_queue_flags, q_full && q_empty)
    // a count that is a multiple of sixteen always gives black
    `ASSERT_IMPLIES(a_color_zero, out_valid && (iter_count[3:0] == 4'd0), pixel_color == '0)

endmodule

@@ tb/sv/escape_time_fractal_iterator_tb.sv @@
module escape_time_fractal_iterator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efi_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [LIMIT_W-1:0] count;
        logic [PIXEL_W-1:0] color;
    } shade_t;

    localparam longint PLANE_MAX = 64'sd2147483647;
    localparam longint PLANE_MIN = -64'sd2147483648;
    localparam longint ESCAPE_SQ = 64'sd4 <<< FRAC_BITS;
    // 0.1 and 0.65 scaled by 2^28, rounded to nearest
    localparam val_t FIXED_C_RE = 32'sd26843546;
    localparam val_t FIXED_C_IM = 32'sd174483046;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [COORD_W-1:0] px = '0;
    logic [COORD_W-1:0] py = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [COORD_W-1:0] out_px;
    logic [COORD_W-1:0] out_py;
    logic [LIMIT_W-1:0] iter_count;
    logic [PIXEL_W-1:0] pixel_color;

    // view registers as the block should hold them
    logic [MODE_W-1:0] view_mode = MODE_MANDEL;
    logic [SCALE_W-1:0] view_scale = 31'd1048576;
    val_t view_ore = -32'sd536870912;
    val_t view_oim = -32'sd536870912;
    val_t view_jre = '0;
    val_t view_jim = '0;
    logic [LIMIT_W-1:0] view_limit = 16'd50;
    logic [COLOR_W-1:0] view_color = 24'hFFFFFF;

    pixel_t pending_pixels[$];
    shade_t expected_shades[$];
    int fails = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    escape_time_fractal_iterator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .px          (px),
        .py          (py),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_px      (out_px),
        .out_py      (out_py),
        .iter_count  (iter_count),
        .pixel_color (pixel_color)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic val_t clamp_plane(input longint v);
        val_t r;
        if (v > PLANE_MAX)
        begin
            r = val_t'(PLANE_MAX);
        end
        else if (v < PLANE_MIN)
        begin
            r = val_t'(PLANE_MIN);
        end
        else
        begin
            r = val_t'(v);
        end
        return r;
    endfunction

    // exact product, floor shift, then clamp
    function automatic val_t fixed_mul(input val_t a, input val_t b, input int sh);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp_plane(p >>> sh);
    endfunction

    function automatic shade_t escape_shade(input logic [COORD_W-1:0] cx,
                                            input logic [COORD_W-1:0] cy);
        shade_t r;
        val_t pre, pim, zr, zi, cr, ci, zr2, zi2, nr, ore, oim;
        int unsigned n;
        ore = view_ore;
        oim = view_oim;
        pre = clamp_plane(longint'(cx) * longint'(view_scale) + longint'(ore));
        pim = clamp_plane(longint'(cy) * longint'(view_scale) + longint'(oim));
        case (view_mode)
            MODE_JULIA:
            begin
                zr = pre;
                zi = pim;
                cr = view_jre;
                ci = view_jim;
            end
            MODE_JULIA_FIX:
            begin
                zr = pre;
                zi = pim;
                cr = FIXED_C_RE;
                ci = FIXED_C_IM;
            end
            default:
            begin
                zr = '0;
                zi = '0;
                cr = pre;
                ci = pim;
            end
        endcase
        zr2 = fixed_mul(zr, zr, FRAC_BITS);
        zi2 = fixed_mul(zi, zi, FRAC_BITS);
        n = 0;
        while (n < view_limit && longint'(zr2) + longint'(zi2) < ESCAPE_SQ)
        begin
            nr = clamp_plane(longint'(clamp_plane(longint'(zr2) - longint'(zi2)))
                             + longint'(cr));
            zi = clamp_plane(longint'(fixed_mul(zr, zi, FRAC_BITS - 1)) + longint'(ci));
            zr = nr;
            zr2 = fixed_mul(zr, zr, FRAC_BITS);
            zi2 = fixed_mul(zi, zi, FRAC_BITS);
            n++;
        end
        r.px = cx;
        r.py = cy;
        r.count = n[LIMIT_W-1:0];
        if (n == view_limit)
        begin
            r.color = '0;
        end
        else
        begin
            r.color = PIXEL_W'(view_color) * PIXEL_W'(n % 16);
        end
        return r;
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_shades.push_back(escape_shade(px, py));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    px <= pending_pixels[0].x;
                    py <= pending_pixels[0].y;
                    void'(pending_pixels.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_shades.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $display("unexpected result: pixel (%0d,%0d) count %0d color %h",
                                 out_px, out_py, iter_count, pixel_color);
                    end
                    fails++;
                end
                else
                begin
                    if (out_px !== expected_shades[0].px || out_py !== expected_shades[0].py
                        || iter_count !== expected_shades[0].count
                        || pixel_color !== expected_shades[0].color)
                    begin
                        if (fails < 10)
                        begin
                            $display("mismatch: got (%0d,%0d) count %0d color %h, %s",
                                     out_px, out_py, iter_count, pixel_color, "expected");
                            $display("          (%0d,%0d) count %0d color %h",
                                     expected_shades[0].px, expected_shades[0].py,
                                     expected_shades[0].count, expected_shades[0].color);
                        end
                        fails++;
                    end
                    void'(expected_shades.pop_front());
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_shades.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:       view_mode = data[MODE_W-1:0];
            REG_SCALE:      view_scale = data[SCALE_W-1:0];
            REG_OFFSET_RE:  view_ore = data;
            REG_OFFSET_IM:  view_oim = data;
            REG_JULIA_RE:   view_jre = data;
            REG_JULIA_IM:   view_jim = data;
            REG_ITER_LIMIT: view_limit = data[LIMIT_W-1:0];
            REG_BASE_COLOR: view_color = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_view(input logic [31:0] d_mode, input logic [31:0] d_scale,
                                input logic [31:0] d_ore, input logic [31:0] d_oim,
                                input logic [31:0] d_jre, input logic [31:0] d_jim,
                                input logic [31:0] d_limit, input logic [31:0] d_color);
        wait_idle();
        write_reg(REG_MODE, d_mode);
        write_reg(REG_SCALE, d_scale);
        write_reg(REG_OFFSET_RE, d_ore);
        write_reg(REG_OFFSET_IM, d_oim);
        write_reg(REG_JULIA_RE, d_jre);
        write_reg(REG_JULIA_IM, d_jim);
        write_reg(REG_ITER_LIMIT, d_limit);
        write_reg(REG_BASE_COLOR, d_color);
        @(negedge clk);
    endtask

    task automatic random_view(input int ph);
        logic [31:0] d_scale, d_ore, d_oim, d_jre, d_jim, d_limit, d_color;
        int sel;
        sel = $urandom_range(0, 9);
        d_scale = $urandom();
        d_ore = $urandom();
        d_oim = $urandom();
        d_jre = $urandom();
        d_jim = $urandom();
        d_limit = $urandom();
        d_color = $urandom();
        // mostly a sensible window onto the set, now and then anything at all
        if (sel < 7)
        begin
            d_scale[SCALE_W-1:0] = SCALE_W'($urandom_range(1 << 14, 1 << 21));
            d_ore = $urandom_range(0, 3 << 28) - (5 << 27);
            d_oim = $urandom_range(0, 3 << 28) - (3 << 27);
            d_jre = $urandom_range(0, 1 << 29) - (1 << 28);
            d_jim = $urandom_range(0, 1 << 29) - (1 << 28);
        end
        else if (sel == 7)
        begin
            d_scale[SCALE_W-1:0] = '0;
        end
        if (ph % 4 == 3)
        begin
            d_limit[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 160));
        end
        else
        begin
            d_limit[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 48));
        end
        if (sel == 2)
        begin
            d_color[COLOR_W-1:0] = '0;
        end
        else if (sel == 3)
        begin
            d_color[COLOR_W-1:0] = '1;
        end
        program_view($urandom(), d_scale, d_ore, d_oim, d_jre, d_jim, d_limit, d_color);
    endtask

    task automatic queue_pixel(input int x, input int y);
        pixel_t p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        pending_pixels.push_back(p);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // view after reset: corners, origin, and c = -1
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(512, 512);
        queue_pixel(256, 512);

        // unused mode code with junk in the upper data bits
        program_view(32'hFFFF_FFFF, 32'h8010_0000, -32'sd536870912, -32'sd536870912,
                     32'h0, 32'h0, 32'hABCD_0014, 32'hFF00_0001);
        queue_pixel(0, 0);
        queue_pixel(512, 512);
        queue_pixel(100, 900);

        // saturated mapping, start value already outside the circle
        program_view(MODE_JULIA, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'd30, 32'h00FF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(1023, 0);

        // fixed constant from the origin
        program_view(MODE_JULIA_FIX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd40,
                     32'h0012_3456);
        queue_pixel(0, 0);
        queue_pixel(777, 333);

        // zero limit
        program_view(MODE_JULIA, 32'd1048576, -32'sd536870912, -32'sd536870912,
                     32'h0666_6666, 32'h0, 32'h0, 32'h00FF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(512, 512);

        // largest limit: c = 0 runs to the end
        program_view(MODE_MANDEL, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF,
                     32'h00FF_FFFF);
        queue_pixel(5, 5);
        program_view(MODE_MANDEL, 32'd1048576, -32'sd536870912, -32'sd536870912,
                     32'h0, 32'h0, 32'h0000_FFFF, 32'h00FF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);

        for (int ph = 0; ph < 12; ph++)
        begin
            random_view(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            repeat (82) queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        end

        wait_idle();
        repeat (300) @(posedge clk);
        if (fails == 0 && expected_shades.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
